>>> hdl/trackball_axis_angle_assert.svh
// Assertion macros for the trackball rotation RTL.
`ifndef TRACKBALL_AXIS_ANGLE_ASSERT_SVH
`define TRACKBALL_AXIS_ANGLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("trackball rotation check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("trackball rotation check failed");

`endif

>>> hdl/tba_pkg.sv
// Shared types and constants for the trackball rotation block.
package tba_pkg;

    localparam int FRACTION_BITS_DEFAULT = 14;
    localparam int COORD_W = 12;
    localparam int CFG_W = 13;
    localparam int OUT_W = 16;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd800;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd800;
    localparam int ANGLE_SCALE = 23040;
    localparam int ANGLE_MAX = 46080;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        ACT_PRESS = 1'b0,
        ACT_DRAG  = 1'b1
    } tba_action_t;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } tba_cfg_idx_t;

    typedef struct packed {
        tba_action_t        action;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } tba_item_t;

    typedef struct packed {
        logic [OUT_W-1:0]        angle;
        logic signed [OUT_W-1:0] axis_x;
        logic signed [OUT_W-1:0] axis_y;
        logic signed [OUT_W-1:0] axis_z;
        logic                    updated;
    } tba_result_t;

    typedef enum logic [5:0] {
        S_IDLE, S_VX, S_VX_W, S_VY, S_VY_W, S_SQX, S_SQY, S_S2,
        S_D, S_D_W, S_ZA, S_ZA_W, S_ZB, S_ZB_W, S_ZDIV, S_ZDIV_W,
        S_ZSQ, S_NSUM, S_N, S_N_W, S_V, S_V_W, S_CLASS, S_DSQ,
        S_DACC, S_LEN, S_LEN_W, S_ANG, S_ANG_C, S_CR, S_CR_ACC,
        S_UPD, S_OUT
    } tba_state_t;

endpackage

>>> hdl/trackball_axis_angle.sv
// Virtual trackball: each pointer event is mapped onto a unit sphere; a press
// remembers the point, a drag turns the change into a rotation axis (previous
// cross new, Q1.FRACTION_BITS) and an angle (Q8.8 degrees, at most 180).
// Every event gives one result word that carries the held angle and axis.
// Each event runs through the shared divider and square-root units, which
// each deliver one bit per cycle. A two-word input queue and an output
// register let events arrive while one is worked on and while a result
// waits to be taken.
module trackball_axis_angle #(
    parameter int FRACTION_BITS = tba_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // pointer_x[11:0], pointer_y[23:12]
    input  logic                      s_tuser,   // action[0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,   // rotation_angle[15:0], axis_x[31:16],
                                                 // axis_y[47:32], axis_z[63:48]
    output logic                      m_tuser,   // rotation_updated[0]
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tba_pkg::CFG_W-1:0] cfg_wdata
);
    import tba_pkg::*;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic             q_valid, q_pop;
    tba_item_t        q_item;
    tba_result_t      result;

    // Window size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (tba_cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tba_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .q_pop(q_pop), .q_valid(q_valid),
        .q_item(q_item)
    );

    tba_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .window_width(width_reg),
        .window_height(height_reg), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .m_valid(m_tvalid), .m_ready(m_tready), .m_result(result)
    );

    // Pack the result word.
    assign m_tdata = {result.axis_z, result.axis_y, result.axis_x, result.angle};
    assign m_tuser = result.updated;

endmodule

>>> hdl/tba_front.sv
// Input side: accepts pointer events, decodes the action and queues them.
module tba_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // pointer_x[11:0], pointer_y[23:12]
    input  logic                         s_tuser,   // action[0]
    input  logic                         q_pop,
    output logic                         q_valid,
    output tba_pkg::tba_item_t           q_item
);
    import tba_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tba_item_t          queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               push, pop;
    tba_item_t          new_item;

    // Decode the incoming word into a queue entry.
    always_comb begin
        new_item.action = tba_action_t'(s_tuser);
        new_item.x      = s_tdata[11:0];
        new_item.y      = s_tdata[23:12];
    end

    assign s_tready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

>>> hdl/tba_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tba_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 28
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                quot_reg <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                quot_reg <= {quot_reg[NUM_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> hdl/tba_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module tba_sqrt #(
    parameter int ARG_W = 52
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [ARG_W-1:0]   arg,
    output logic               busy,
    output logic               done,
    output logic [ARG_W/2-1:0] root
);
    localparam int ROOT_W = ARG_W / 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [ARG_W-1:0]  arg_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;
    logic [ROOT_W+2:0] shifted, trial;
    logic              fits;

    // Shift in the next two bits and test against 4*root+1.
    assign shifted = {rem_reg, arg_reg[ARG_W-1:ARG_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = (shifted >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
                arg_reg  <= arg;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                arg_reg  <= {arg_reg[ARG_W-3:0], 2'b00};
                rem_reg  <= fits ? (ROOT_W+1)'(shifted - trial) : (ROOT_W+1)'(shifted);
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> hdl/tba_back.sv
// Back end: maps each event onto the ball and updates the held rotation.
`include "trackball_axis_angle_assert.svh"
module tba_back #(
    parameter int FRACTION_BITS = tba_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tba_pkg::CFG_W-1:0]   window_width,
    input  logic [tba_pkg::CFG_W-1:0]   window_height,
    input  logic                        q_valid,
    input  tba_pkg::tba_item_t          q_item,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tba_pkg::tba_result_t        m_result
);
    import tba_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int VW = F + 12;
    localparam int CW = F + 3;
    localparam int PW = 2 * VW;
    localparam int SW = 2 * F + 24;
    localparam int RW = SW / 2;
    localparam int NW = 2 * F + 13;
    localparam int DW = F + 14;
    localparam logic [NW-1:0] VMAX_N = (NW'(2048) << F) - NW'(1);
    localparam logic [NW-1:0] Z_NUM = NW'(2) << (2 * F);
    localparam logic [RW-1:0] TWO_ONE_R = RW'(2) << F;
    localparam logic [RW-1:0] FOUR_ONE_R = RW'(4) << F;
    localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
    localparam int LIM = (F > 14) ? 32767 : (1 << F);
    localparam logic [PW-1:0] LIM_P = PW'(LIM);
    localparam logic [PW-1:0] ANG_MAX_P = PW'(ANGLE_MAX);

    tba_state_t              state_reg, state_next;
    logic [1:0]              k_reg;
    logic [2:0]              j_reg;
    logic                    drag_reg;
    logic                    upd_reg;
    logic signed [15:0]      nx_reg, ny_reg;
    logic signed [VW-1:0]    vx_reg, vy_reg, z_reg;
    logic [SW-1:0]           acc_reg;
    logic signed [PW-1:0]    prod_reg, xacc_reg;
    logic [RW-1:0]           d_reg, n_reg;
    logic signed [CW-1:0]    cur_reg [3];
    logic signed [CW-1:0]    prev_reg [3];
    logic signed [15:0]      axis_reg [3];
    logic [15:0]             angle_reg;
    logic                    out_valid_reg;
    tba_result_t             out_reg;

    logic [CFG_W-1:0]        w_eff, h_eff;
    logic                    div_start, div_busy, div_done;
    logic [NW-1:0]           div_num, div_quot;
    logic [DW-1:0]           div_den;
    logic                    sqrt_start, sqrt_busy, sqrt_done;
    logic [SW-1:0]           sqrt_arg;
    logic [RW-1:0]           sqrt_root;
    logic signed [VW-1:0]    mul_a, mul_b;
    logic signed [VW-1:0]    comp_k;
    logic [VW-1:0]           comp_mag;
    logic [15:0]             nx_mag, ny_mag;
    logic signed [CW:0]      diff_k;
    logic [NW-1:0]           vq_clamp;
    logic [VW-1:0]           vq_mag;
    logic [CW-1:0]           cq_mag;
    logic [PW-1:0]           ang_shift;
    logic signed [PW-1:0]    cr_diff;
    logic [PW-1:0]           cr_mag, cr_q, cr_c;
    logic                    same_vec, out_load;

    assign w_eff = (window_width == '0) ? CFG_W'(1) : window_width;
    assign h_eff = (window_height == '0) ? CFG_W'(1) : window_height;

    tba_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .den(div_den), .busy(div_busy), .done(div_done), .quot(div_quot)
    );

    tba_sqrt #(.ARG_W(SW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start), .arg(sqrt_arg),
        .busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
    );

    // Operand selection for the loop indexes.
    always_comb begin
        unique case (k_reg)
            2'd0: comp_k = vx_reg;
            2'd1: comp_k = vy_reg;
            default: comp_k = z_reg;
        endcase
        unique case (k_reg)
            2'd0: diff_k = (CW+1)'(prev_reg[0]) - (CW+1)'(cur_reg[0]);
            2'd1: diff_k = (CW+1)'(prev_reg[1]) - (CW+1)'(cur_reg[1]);
            default: diff_k = (CW+1)'(prev_reg[2]) - (CW+1)'(cur_reg[2]);
        endcase
    end

    assign comp_mag = comp_k[VW-1] ? VW'(-comp_k) : VW'(comp_k);
    assign nx_mag   = nx_reg[15] ? 16'(-nx_reg) : 16'(nx_reg);
    assign ny_mag   = ny_reg[15] ? 16'(-ny_reg) : 16'(ny_reg);
    assign same_vec = (cur_reg[0] == prev_reg[0]) && (cur_reg[1] == prev_reg[1])
                   && (cur_reg[2] == prev_reg[2]);

    // Quotient post-processing: saturate mapped coordinates, size components.
    assign vq_clamp = (div_quot > VMAX_N) ? VMAX_N : div_quot;
    assign vq_mag   = VW'(vq_clamp);
    assign cq_mag   = CW'(div_quot);

    // Angle scaling and cross product rounding.
    assign ang_shift = ($unsigned(prod_reg) + HALF_P) >> F;
    assign cr_diff   = xacc_reg - prod_reg;
    assign cr_mag    = cr_diff[PW-1] ? PW'(-cr_diff) : PW'(cr_diff);
    assign cr_q      = (cr_mag + HALF_P) >> F;
    assign cr_c      = (cr_q > LIM_P) ? LIM_P : cr_q;

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_VX;
            S_VX:     state_next = S_VX_W;
            S_VX_W:   if (div_done) state_next = S_VY;
            S_VY:     state_next = S_VY_W;
            S_VY_W:   if (div_done) state_next = S_SQX;
            S_SQX:    state_next = S_SQY;
            S_SQY:    state_next = S_S2;
            S_S2:     state_next = S_D;
            S_D:      state_next = S_D_W;
            S_D_W: begin
                if (sqrt_done) begin
                    state_next = (sqrt_root <= TWO_ONE_R) ? S_ZA : S_ZB;
                end
            end
            S_ZA:     state_next = S_ZA_W;
            S_ZA_W:   if (sqrt_done) state_next = S_ZSQ;
            S_ZB:     state_next = S_ZB_W;
            S_ZB_W:   if (sqrt_done) state_next = S_ZDIV;
            S_ZDIV:   state_next = S_ZDIV_W;
            S_ZDIV_W: if (div_done) state_next = S_ZSQ;
            S_ZSQ:    state_next = S_NSUM;
            S_NSUM:   state_next = S_N;
            S_N:      state_next = S_N_W;
            S_N_W:    if (sqrt_done) state_next = S_V;
            S_V:      state_next = S_V_W;
            S_V_W: begin
                if (div_done) begin
                    state_next = (k_reg == 2'd2) ? S_CLASS : S_V;
                end
            end
            S_CLASS: begin
                if (!drag_reg || same_vec) state_next = S_OUT;
                else state_next = S_DSQ;
            end
            S_DSQ:    state_next = S_DACC;
            S_DACC:   state_next = (k_reg == 2'd2) ? S_LEN : S_DSQ;
            S_LEN:    state_next = S_LEN_W;
            S_LEN_W:  if (sqrt_done) state_next = S_ANG;
            S_ANG:    state_next = S_ANG_C;
            S_ANG_C:  state_next = S_CR;
            S_CR:     state_next = S_CR_ACC;
            S_CR_ACC: state_next = (j_reg == 3'd5) ? S_UPD : S_CR;
            S_UPD:    state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Unit controls and operands.
    always_comb begin
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        sqrt_start = 1'b0;
        sqrt_arg   = '0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            S_IDLE: q_pop = q_valid;
            S_VX: begin
                div_start = 1'b1;
                div_num   = (NW'(nx_mag) << (F + 1)) + NW'(w_eff);
                div_den   = DW'({w_eff, 1'b0});
            end
            S_VY: begin
                div_start = 1'b1;
                div_num   = (NW'(ny_mag) << (F + 1)) + NW'(h_eff);
                div_den   = DW'({h_eff, 1'b0});
            end
            S_SQX: begin
                mul_a = vx_reg;
                mul_b = vx_reg;
            end
            S_SQY: begin
                mul_a = vy_reg;
                mul_b = vy_reg;
            end
            S_D, S_N, S_LEN: begin
                sqrt_start = 1'b1;
                sqrt_arg   = acc_reg;
            end
            S_ZA: begin
                sqrt_start = 1'b1;
                sqrt_arg   = SW'(FOUR_ONE_R - d_reg) << F;
            end
            S_ZB: begin
                sqrt_start = 1'b1;
                sqrt_arg   = SW'(d_reg) << F;
            end
            S_ZDIV: begin
                div_start = 1'b1;
                div_num   = Z_NUM;
                div_den   = DW'(n_reg);
            end
            S_ZSQ: begin
                mul_a = z_reg;
                mul_b = z_reg;
            end
            S_V: begin
                div_start = 1'b1;
                div_num   = (NW'(comp_mag) << (F + 1)) + NW'(n_reg);
                div_den   = DW'({n_reg, 1'b0});
            end
            S_DSQ: begin
                mul_a = VW'(diff_k);
                mul_b = VW'(diff_k);
            end
            S_ANG: begin
                mul_a = $signed(d_reg);
                mul_b = VW'(ANGLE_SCALE);
            end
            S_CR: begin
                unique case (j_reg)
                    3'd0: begin mul_a = VW'(prev_reg[1]); mul_b = VW'(cur_reg[2]); end
                    3'd1: begin mul_a = VW'(prev_reg[2]); mul_b = VW'(cur_reg[1]); end
                    3'd2: begin mul_a = VW'(prev_reg[2]); mul_b = VW'(cur_reg[0]); end
                    3'd3: begin mul_a = VW'(prev_reg[0]); mul_b = VW'(cur_reg[2]); end
                    3'd4: begin mul_a = VW'(prev_reg[0]); mul_b = VW'(cur_reg[1]); end
                    default: begin mul_a = VW'(prev_reg[1]); mul_b = VW'(cur_reg[0]); end
                endcase
            end
            default: ;
        endcase
    end

    // Shared multiplier with its product register.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                drag_reg <= (q_item.action == ACT_DRAG);
                nx_reg   <= $signed({1'b0, q_item.x, 3'b000}) - $signed({3'b000, w_eff});
                ny_reg   <= $signed({3'b000, h_eff}) - $signed({1'b0, q_item.y, 3'b000});
            end
            S_VX_W: if (div_done) vx_reg <= nx_reg[15] ? -$signed(vq_mag) : $signed(vq_mag);
            S_VY_W: if (div_done) vy_reg <= ny_reg[15] ? -$signed(vq_mag) : $signed(vq_mag);
            S_SQY:  acc_reg <= SW'($unsigned(prod_reg));
            S_S2, S_NSUM, S_DACC: acc_reg <= acc_reg + SW'($unsigned(prod_reg));
            S_D_W, S_LEN_W: if (sqrt_done) d_reg <= sqrt_root;
            S_ZA_W: if (sqrt_done) z_reg <= $signed(VW'(sqrt_root));
            S_ZB_W, S_N_W: if (sqrt_done) n_reg <= sqrt_root;
            S_ZDIV_W: if (div_done) z_reg <= $signed(VW'(div_quot));
            S_V_W: begin
                if (div_done) begin
                    cur_reg[k_reg] <= comp_k[VW-1] ? -$signed(cq_mag) : $signed(cq_mag);
                end
            end
            S_CLASS: begin
                acc_reg <= '0;
                // Remember whether this drag moves the rotation before the
                // previous vector is overwritten.
                upd_reg <= drag_reg && !same_vec;
            end
            S_CR_ACC: if (!j_reg[0]) xacc_reg <= prod_reg;
            default: ;
        endcase
    end

    // Loop counters, held rotation state and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            j_reg         <= '0;
            angle_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
                axis_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_N_W || state_reg == S_CLASS) begin
                k_reg <= '0;
            end else if ((state_reg == S_V_W && div_done) || state_reg == S_DACC) begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == S_ANG_C) begin
                j_reg <= '0;
            end else if (state_reg == S_CR_ACC) begin
                j_reg <= j_reg + 1'b1;
            end
            if (state_reg == S_CLASS && !drag_reg) begin
                angle_reg <= '0;
                prev_reg  <= cur_reg;
            end
            if (state_reg == S_ANG_C) begin
                angle_reg <= (ang_shift > ANG_MAX_P) ? 16'(ANGLE_MAX) : ang_shift[15:0];
            end
            if (state_reg == S_CR_ACC && j_reg[0]) begin
                axis_reg[j_reg[2:1]] <= cr_diff[PW-1] ? -$signed(16'(cr_c)) : $signed(16'(cr_c));
            end
            if (state_reg == S_UPD) begin
                prev_reg <= cur_reg;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word, loaded when the output register is free.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.angle   <= angle_reg;
            out_reg.axis_x  <= axis_reg[0];
            out_reg.axis_y  <= axis_reg[1];
            out_reg.axis_z  <= axis_reg[2];
            out_reg.updated <= upd_reg;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `TBA_ASSERT_IMP(a_angle_bound, aclk, aresetn, out_valid_reg, out_reg.angle <= 16'(ANGLE_MAX))
    `TBA_ASSERT_IMP(a_axis_bound, aclk, aresetn, out_valid_reg, (int'(out_reg.axis_x) <= LIM) && (int'(out_reg.axis_x) >= -LIM) && (int'(out_reg.axis_z) <= LIM) && (int'(out_reg.axis_z) >= -LIM))
    `TBA_ASSERT_IMP(a_div_free, aclk, aresetn, div_start, !div_busy && !sqrt_start)
    `TBA_ASSERT_NEXT(a_press_clears, aclk, aresetn, state_reg == S_CLASS && !drag_reg, angle_reg == '0)

endmodule

>>> dv/trackball_axis_angle_checker.sv
// Checker for the trackball rotation block: predicts each result word and compares it.
module trackball_axis_angle_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [23:0]               s_tdata,   // pointer_x[11:0], pointer_y[23:12]
    input  logic                      s_tuser,   // action[0]
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [63:0]               m_tdata,   // rotation_angle[15:0], axis_x[31:16],
                                                 // axis_y[47:32], axis_z[63:48]
    input  logic                      m_tuser,   // rotation_updated[0]
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tba_pkg::CFG_W-1:0] cfg_wdata,
    output int                        fail_count,
    output int                        words_pending
);
    import tba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRACTION_BITS_DEFAULT;
    localparam longint ONE = longint'(1) << FB;

    typedef longint vec3_t [3];

    typedef struct {
        logic [15:0] angle;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic        updated;
    } rotation_t;

    // Mirror of the block's state and window size.
    logic [CFG_W-1:0] win_w, win_h;
    vec3_t            last_vec;
    vec3_t            axis_held;
    longint           angle_held;
    rotation_t        rotation_q[$];

    // Floor of the square root, one result bit per pass.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Division rounded half away from zero; den is positive.
    function automatic longint div_nearest(longint num, longint den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Drop the fraction bits, rounding half away from zero.
    function automatic longint drop_fraction(longint v);
        longint unsigned mag, q;
        mag = (v < 0) ? longint'(-v) : v;
        q = (mag + (longint'(1) << (FB - 1))) >> FB;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint limit_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Map a pointer position to a unit vector on the ball.
    function automatic vec3_t ball_point(longint x, longint y);
        longint vmax, w, h, vx, vy, z;
        longint unsigned s2, d, r, n;
        vec3_t vec;
        vmax = (longint'(2048) << FB) - 1;
        w = (win_w == 0) ? 1 : win_w;
        h = (win_h == 0) ? 1 : win_h;
        vx = limit_to(div_nearest((8 * x - w) * ONE, w), vmax);
        vy = limit_to(div_nearest((h - 8 * y) * ONE, h), vmax);
        s2 = vx * vx + vy * vy;
        d = floor_sqrt(s2);
        if (d <= 2 * ONE) begin
            z = floor_sqrt((4 * ONE - d) << FB);
        end else begin
            r = floor_sqrt(d << FB);
            z = (longint'(2) << (2 * FB)) / r;
        end
        n = floor_sqrt(s2 + z * z);
        vec[0] = div_nearest(vx * ONE, n);
        vec[1] = div_nearest(vy * ONE, n);
        vec[2] = div_nearest(z * ONE, n);
        return vec;
    endfunction

    // Apply one pointer event and return the word it produces.
    function automatic rotation_t apply_event(tba_action_t act, longint x, longint y);
        vec3_t     cur;
        longint    d0, d1, d2;
        longint unsigned len, ang;
        rotation_t res;
        cur = ball_point(x, y);
        res.updated = 1'b0;
        if (act == ACT_PRESS) begin
            angle_held = 0;
            last_vec = cur;
        end else begin
            d0 = last_vec[0] - cur[0];
            d1 = last_vec[1] - cur[1];
            d2 = last_vec[2] - cur[2];
            if (d0 != 0 || d1 != 0 || d2 != 0) begin
                len = floor_sqrt(d0 * d0 + d1 * d1 + d2 * d2);
                ang = (len * ANGLE_SCALE + (longint'(1) << (FB - 1))) >> FB;
                angle_held = (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
                axis_held[0] = limit_to(drop_fraction(last_vec[1] * cur[2]
                                                      - last_vec[2] * cur[1]), ONE);
                axis_held[1] = limit_to(drop_fraction(last_vec[2] * cur[0]
                                                      - last_vec[0] * cur[2]), ONE);
                axis_held[2] = limit_to(drop_fraction(last_vec[0] * cur[1]
                                                      - last_vec[1] * cur[0]), ONE);
                last_vec = cur;
                res.updated = 1'b1;
            end
        end
        res.angle = angle_held[15:0];
        res.ax = axis_held[0][15:0];
        res.ay = axis_held[1][15:0];
        res.az = axis_held[2][15:0];
        return res;
    endfunction

    // Watch both channels and the register port at each rising edge.
    always @(posedge aclk) begin
        rotation_t want;
        int in_n, out_n;
        in_n = 0;
        out_n = 0;
        if (!aresetn) begin
            win_w = WIDTH_RESET;
            win_h = HEIGHT_RESET;
            angle_held = 0;
            for (int i = 0; i < 3; i++) begin
                last_vec[i] = 0;
                axis_held[i] = 0;
            end
            rotation_q.delete();
            fail_count <= 0;
            words_pending <= 0;
        end else begin
            if (cfg_we) begin
                if (tba_cfg_idx_t'(cfg_index) == CFG_WIDTH) win_w = cfg_wdata;
                else win_h = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                rotation_q.push_back(apply_event(tba_action_t'(s_tuser),
                                                 s_tdata[11:0], s_tdata[23:12]));
                in_n = 1;
            end
            if (m_tvalid && m_tready) begin
                out_n = 1;
                if (rotation_q.size() == 0) begin
                    $error("result word with no pending event");
                    fail_count <= fail_count + 1;
                end else begin
                    want = rotation_q.pop_front();
                    if (m_tdata[15:0] !== want.angle ||
                        m_tdata[31:16] !== want.ax ||
                        m_tdata[47:32] !== want.ay ||
                        m_tdata[63:48] !== want.az ||
                        m_tuser !== want.updated) begin
                        fail_count <= fail_count + 1;
                        if (m_tdata[15:0] !== want.angle)
                            $error("rotation_angle: expected %0d, got %0d",
                                   want.angle, m_tdata[15:0]);
                        if (m_tdata[31:16] !== want.ax)
                            $error("axis_x: expected %0d, got %0d",
                                   $signed(want.ax), $signed(m_tdata[31:16]));
                        if (m_tdata[47:32] !== want.ay)
                            $error("axis_y: expected %0d, got %0d",
                                   $signed(want.ay), $signed(m_tdata[47:32]));
                        if (m_tdata[63:48] !== want.az)
                            $error("axis_z: expected %0d, got %0d",
                                   $signed(want.az), $signed(m_tdata[63:48]));
                        if (m_tuser !== want.updated)
                            $error("rotation_updated: expected %0d, got %0d",
                                   want.updated, m_tuser);
                    end
                end
            end
            words_pending <= words_pending + in_n - ((out_n && words_pending + in_n > 0) ? 1 : 0);
        end
    end
endmodule

>>> dv/trackball_axis_angle_tb.sv
// Testbench top for the trackball rotation block: stimulus, clocking and verdict.
module trackball_axis_angle_tb;
    import tba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // pointer_x[11:0], pointer_y[23:12]
    logic                 s_tuser;   // action[0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;   // rotation_angle[15:0], axis_x[31:16],
                                     // axis_y[47:32], axis_z[63:48]
    logic                 m_tuser;   // rotation_updated[0]
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   fail_count;
    int                   words_pending;
    logic                 steady;    // no idling on either side while set
    int                   win_w, win_h;

    trackball_axis_angle dut (.*);

    trackball_axis_angle_checker chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Receiver stalls at random outside the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 19);
    end

    // Offer one word, sometimes after a random gap, and wait for its acceptance.
    task automatic send_event(tba_action_t act, int x, int y);
        if (!steady && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {x[11:0], y[11:0]} == 0 ? 24'd0 : {y[11:0], x[11:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic set_window(int w, int h);
        s_tvalid <= 1'b0;
        // Let the pending count see a word accepted at the last edge.
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_wdata <= w[CFG_W-1:0];
        @(posedge aclk);
        cfg_index <= CFG_HEIGHT;
        cfg_wdata <= h[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        win_w = (w == 0) ? 1 : w;
        win_h = (h == 0) ? 1 : h;
    endtask

    // Mostly a coordinate over the window's ball area, sometimes anywhere.
    function automatic int pick_coord(int dim);
        int top;
        if ($urandom_range(9) == 0) return $urandom_range(4095);
        top = dim / 4 + 1;
        return $urandom_range((top > 4095) ? 4095 : top);
    endfunction

    function automatic int nudge(int v, int dim);
        int step, r;
        step = dim / 16 + 2;
        r = v + $urandom_range(2 * step) - step;
        return (r < 0) ? 0 : (r > 4095) ? 4095 : r;
    endfunction

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int sent, x, y, drags;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        steady = 1'b0;
        win_w = 800;
        win_h = 800;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed events at the reset window size.
        send_event(ACT_DRAG, 0, 0);          // drag before any press
        send_event(ACT_PRESS, 0, 0);
        send_event(ACT_DRAG, 4095, 4095);
        send_event(ACT_DRAG, 4095, 4095);    // unchanged drag
        send_event(ACT_PRESS, 100, 100);     // ball center
        send_event(ACT_DRAG, 200, 100);
        send_event(ACT_DRAG, 100, 0);
        send_event(ACT_PRESS, 0, 100);       // opposite edges for the angle bound
        send_event(ACT_DRAG, 200, 100);
        send_event(ACT_DRAG, 2730, 1365);    // alternating bit patterns
        send_event(ACT_DRAG, 1365, 2730);

        // Zero window size and saturated coordinates.
        set_window(0, 0);
        send_event(ACT_PRESS, 0, 0);
        send_event(ACT_DRAG, 4095, 0);
        send_event(ACT_DRAG, 0, 4095);
        send_event(ACT_DRAG, 4095, 4095);

        // Largest register values and mixed extremes.
        set_window(8191, 8191);
        send_event(ACT_PRESS, 1024, 1024);
        send_event(ACT_DRAG, 4095, 0);
        send_event(ACT_DRAG, 0, 4095);
        set_window(4096, 1);
        send_event(ACT_PRESS, 512, 0);
        send_event(ACT_DRAG, 0, 1);
        set_window(1, 4096);
        send_event(ACT_PRESS, 0, 512);
        send_event(ACT_DRAG, 1, 4095);

        // Random gestures: a press then a run of nearby drags, with some noise.
        sent = 0;
        while (sent < 650) begin
            if (sent % 120 == 0) begin
                case ($urandom_range(4))
                    0: set_window($urandom_range(1, 15), $urandom_range(1, 15));
                    1: set_window(4096, 4096);
                    2: set_window($urandom_range(8191), $urandom_range(8191));
                    default: set_window($urandom_range(16, 4096), $urandom_range(16, 4096));
                endcase
            end
            steady = (sent >= 300 && sent < 400);
            if ($urandom_range(9) == 0) begin
                send_event(tba_action_t'($urandom_range(1)), $urandom_range(4095),
                           $urandom_range(4095));
                sent++;
            end else begin
                x = pick_coord(win_w);
                y = pick_coord(win_h);
                send_event(ACT_PRESS, x, y);
                drags = $urandom_range(1, 8);
                for (int i = 0; i < drags; i++) begin
                    if ($urandom_range(5) != 0) begin
                        x = nudge(x, win_w);
                        y = nudge(y, win_h);
                    end
                    send_event(ACT_DRAG, x, y);
                end
                sent += drags + 1;
            end
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        // Drain, then keep watching for stray words before the verdict.
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
